FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each expands to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge while reset is released.
`define RRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RRQ_ASSERT(label, prop, msg)
`define RRQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hw/rtl/rrqsd_pkg.sv
`timescale 1ns / 1ps
package rrqsd_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int NUM_SERVERS = 8;
  localparam int QUEUE_DEPTH = 32;
  localparam int STACK_DEPTH = 64;

  localparam int QW     = $clog2(NUM_QUEUES);
  localparam int SW     = $clog2(NUM_SERVERS);
  localparam int QDW    = $clog2(QUEUE_DEPTH);
  localparam int SDW    = $clog2(STACK_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW    = $clog2(STACK_DEPTH + 1);
  localparam int NQ_W   = $clog2(NUM_QUEUES + 1);
  localparam int NS_W   = $clog2(NUM_SERVERS + 1);
  localparam int MAXN   = (NUM_QUEUES > NUM_SERVERS) ? NUM_QUEUES : NUM_SERVERS;
  localparam int SCAN_W = $clog2(MAXN + 1);

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int JOB_W     = 24;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_READ     = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_QUEUE_FULL  = 3'd1,
    STS_NO_DISPATCH = 3'd2,
    STS_STACK_FULL  = 3'd3,
    STS_EMPTY       = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS = 1'd1;

  localparam logic [QCW-1:0]   QUEUE_FULL_CNT = QCW'(QUEUE_DEPTH);
  localparam logic [SCW-1:0]   STACK_FULL_CNT = SCW'(STACK_DEPTH);
  localparam logic [QDW-1:0]   QPTR_LAST      = QDW'(QUEUE_DEPTH - 1);
  localparam logic [CFG_W-1:0] CFG_NQ_MAX     = CFG_W'(NUM_QUEUES);
  localparam logic [CFG_W-1:0] CFG_NS_MAX     = CFG_W'(NUM_SERVERS);

endpackage

FILE: hw/rtl/round_robin_queue_to_stack_dealer_top.sv
`timescale 1ns / 1ps
// A load goes through ST_LOAD and ST_DONE to the result register. A dispatch scans queues in
// ST_SCAN, one per cycle, visiting from 1 up to the active queue count of them, then moves a
// job through ST_DREAD, or ends in an error status straight from the scan; a read scans the 8
// stacks the same way and fetches through ST_RREAD. One request is in flight at a time, a finished result waits
// while the previous one is unaccepted, and the next request is taken in the cycle after the
// result register is loaded. Reset (rst_ni low, asynchronous) empties all queues and stacks.
`include "assert_macros.svh"
module round_robin_queue_to_stack_dealer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrqsd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrqsd_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [2:0]                    queue_index_i,
  input  logic [7:0]                    pref_server_i,
  input  logic [15:0]                   duration_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [2:0]                    server_index_o,
  output logic [2:0]                    source_index_o,
  output logic [7:0]                    job_pref_server_o,
  output logic [15:0]                   job_duration_o
);
  import rrqsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DREAD,
    ST_RREAD,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]  queues_cfg_q, servers_cfg_q;
  logic [QDW-1:0]    q_head_q [NUM_QUEUES];
  logic [QDW-1:0]    q_tail_q [NUM_QUEUES];
  logic [QCW-1:0]    q_cnt_q  [NUM_QUEUES];
  logic [SCW-1:0]    s_cnt_q  [NUM_SERVERS];
  logic [QW-1:0]     source_turn_q;
  logic [SW-1:0]     server_turn_q;
  logic [SW-1:0]     readout_q;

  req_e              req_q;
  logic [QW-1:0]     qi_q;
  logic [JOB_W-1:0]  job_in_q;
  logic [QW-1:0]     scan_q_q;
  logic [SW-1:0]     scan_s_q;
  logic [SCAN_W-1:0] scan_cnt_q;
  logic [SW-1:0]     srv_q;

  status_e           res_status_q;
  logic [SW-1:0]     res_srv_q;
  logic [QW-1:0]     res_src_q;
  logic [JOB_W-1:0]  res_job_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [SW-1:0]     out_srv_q;
  logic [QW-1:0]     out_src_q;
  logic [JOB_W-1:0]  out_job_q;

  // Job memories.
  logic [JOB_W-1:0]  q_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [JOB_W-1:0]  s_mem [NUM_SERVERS * STACK_DEPTH];
  logic [JOB_W-1:0]  q_rdata_q, s_rdata_q;

  logic [NQ_W-1:0]   nq;
  logic [NS_W-1:0]   ns;
  logic              load_ok;
  logic              scan_hit, stack_full, scan_last;
  logic [QW-1:0]     scan_q_next;
  logic [SW-1:0]     scan_s_next;
  logic              q_we, q_re, s_we, s_re;
  logic [QW+QDW-1:0] q_waddr, q_raddr;
  logic [SW+SDW-1:0] s_waddr, s_raddr;
  logic [SCW-1:0]    s_top;

  always_comb begin
    if (queues_cfg_q == '0) begin
      nq = NQ_W'(1);
    end else if (queues_cfg_q > CFG_NQ_MAX) begin
      nq = NQ_W'(NUM_QUEUES);
    end else begin
      nq = NQ_W'(queues_cfg_q);
    end
    if (servers_cfg_q == '0) begin
      ns = NS_W'(1);
    end else if (servers_cfg_q > CFG_NS_MAX) begin
      ns = NS_W'(NUM_SERVERS);
    end else begin
      ns = NS_W'(servers_cfg_q);
    end
  end

  assign load_ok    = (NQ_W'(qi_q) < nq) && (q_cnt_q[qi_q] < QUEUE_FULL_CNT);
  assign scan_hit   = (q_cnt_q[scan_q_q] != '0);
  assign stack_full = (s_cnt_q[srv_q] >= STACK_FULL_CNT);
  assign s_top      = s_cnt_q[scan_s_q] - SCW'(1);

  always_comb begin
    if (req_q == REQ_DISPATCH) begin
      scan_last = (SCAN_W'(scan_cnt_q + SCAN_W'(1)) == SCAN_W'(nq));
    end else begin
      scan_last = (SCAN_W'(scan_cnt_q + SCAN_W'(1)) == SCAN_W'(NUM_SERVERS));
    end
    if (NQ_W'(scan_q_q) + NQ_W'(1) >= nq) begin
      scan_q_next = '0;
    end else begin
      scan_q_next = QW'(scan_q_q + QW'(1));
    end
    if (scan_s_q == SW'(NUM_SERVERS - 1)) begin
      scan_s_next = '0;
    end else begin
      scan_s_next = SW'(scan_s_q + SW'(1));
    end
  end

  assign q_we    = (state_q == ST_LOAD) && load_ok;
  assign q_waddr = {qi_q, q_tail_q[qi_q]};
  assign q_re    = (state_q == ST_SCAN) && (req_q == REQ_DISPATCH) && scan_hit && !stack_full;
  assign q_raddr = {scan_q_q, q_head_q[scan_q_q]};
  assign s_we    = (state_q == ST_DREAD);
  assign s_waddr = {srv_q, s_cnt_q[srv_q][SDW-1:0]};
  assign s_re    = (state_q == ST_SCAN) && (req_q == REQ_READ) && (s_cnt_q[scan_s_q] != '0);
  assign s_raddr = {scan_s_q, s_top[SDW-1:0]};

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= job_in_q;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= q_rdata_q;
    end
    if (s_re) begin
      s_rdata_q <= s_mem[s_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      queues_cfg_q  <= CFG_NQ_MAX;
      servers_cfg_q <= CFG_NS_MAX;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head_q[i] <= '0;
        q_tail_q[i] <= '0;
        q_cnt_q[i]  <= '0;
      end
      for (int i = 0; i < NUM_SERVERS; i++) begin
        s_cnt_q[i] <= '0;
      end
      source_turn_q <= '0;
      server_turn_q <= '0;
      readout_q     <= '0;
      req_q         <= REQ_NONE;
      qi_q          <= '0;
      job_in_q      <= '0;
      scan_q_q      <= '0;
      scan_s_q      <= '0;
      scan_cnt_q    <= '0;
      srv_q         <= '0;
      res_status_q  <= STS_OK;
      res_srv_q     <= '0;
      res_src_q     <= '0;
      res_job_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= STS_OK;
      out_srv_q     <= '0;
      out_src_q     <= '0;
      out_job_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_QUEUES) begin
          queues_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_SERVERS) begin
          servers_cfg_q <= cfg_data_i;
        end
      end

      // In ST_DONE the result register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q      <= req_e'(req_type_i);
            qi_q       <= queue_index_i;
            job_in_q   <= {pref_server_i, duration_i};
            scan_cnt_q <= '0;
            scan_q_q   <= (NQ_W'(source_turn_q) < nq) ? source_turn_q : '0;
            scan_s_q   <= readout_q;
            srv_q      <= (NS_W'(server_turn_q) < ns) ? server_turn_q : '0;
            res_status_q <= STS_OK;
            res_srv_q    <= '0;
            res_src_q    <= '0;
            res_job_q    <= '0;
            unique case (req_e'(req_type_i))
              REQ_LOAD:     state_q <= ST_LOAD;
              REQ_DISPATCH: state_q <= ST_SCAN;
              REQ_READ:     state_q <= ST_SCAN;
              REQ_NONE:     state_q <= ST_IDLE;
            endcase
          end
        end

        ST_LOAD: begin
          if (load_ok) begin
            q_tail_q[qi_q] <= (q_tail_q[qi_q] == QPTR_LAST) ? '0 :
                              QDW'(q_tail_q[qi_q] + QDW'(1));
            q_cnt_q[qi_q]  <= QCW'(q_cnt_q[qi_q] + QCW'(1));
          end else begin
            res_status_q <= STS_QUEUE_FULL;
          end
          state_q <= ST_DONE;
        end

        ST_SCAN: begin
          if (req_q == REQ_DISPATCH) begin
            if (scan_hit) begin
              if (stack_full) begin
                res_status_q <= STS_STACK_FULL;
                state_q      <= ST_DONE;
              end else begin
                state_q <= ST_DREAD;
              end
            end else if (scan_last) begin
              res_status_q <= STS_NO_DISPATCH;
              state_q      <= ST_DONE;
            end else begin
              scan_cnt_q <= SCAN_W'(scan_cnt_q + SCAN_W'(1));
              scan_q_q   <= scan_q_next;
            end
          end else begin
            if (s_cnt_q[scan_s_q] != '0) begin
              s_cnt_q[scan_s_q] <= s_top;
              readout_q         <= scan_s_q;
              res_srv_q         <= scan_s_q;
              state_q           <= ST_RREAD;
            end else if (scan_last) begin
              readout_q    <= '0;
              res_status_q <= STS_EMPTY;
              state_q      <= ST_DONE;
            end else begin
              scan_cnt_q <= SCAN_W'(scan_cnt_q + SCAN_W'(1));
              scan_s_q   <= scan_s_next;
            end
          end
        end

        ST_DREAD: begin
          q_head_q[scan_q_q] <= (q_head_q[scan_q_q] == QPTR_LAST) ? '0 :
                                QDW'(q_head_q[scan_q_q] + QDW'(1));
          q_cnt_q[scan_q_q]  <= QCW'(q_cnt_q[scan_q_q] - QCW'(1));
          s_cnt_q[srv_q]     <= SCW'(s_cnt_q[srv_q] + SCW'(1));
          source_turn_q      <= scan_q_next;
          server_turn_q      <= (NS_W'(srv_q) + NS_W'(1) >= ns) ? '0 : SW'(srv_q + SW'(1));
          res_srv_q          <= srv_q;
          res_src_q          <= scan_q_q;
          res_job_q          <= q_rdata_q;
          state_q            <= ST_DONE;
        end

        ST_RREAD: begin
          res_job_q <= s_rdata_q;
          state_q   <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_srv_q    <= res_srv_q;
            out_src_q    <= res_src_q;
            out_job_q    <= res_job_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign server_index_o    = out_srv_q;
  assign source_index_o    = out_src_q;
  assign job_pref_server_o = out_job_q[JOB_W-1:16];
  assign job_duration_o    = out_job_q[15:0];

  `RRQ_ASSERT(a_busy_after_accept,
    (in_valid_i && in_ready_o && (req_type_i != REQ_NONE)) |=> !in_ready_o,
    "block still ready after taking a request")
  `RRQ_ASSERT(a_dispatch_legal,
    (state_q == ST_DREAD) |-> ((q_cnt_q[scan_q_q] != '0) && (s_cnt_q[srv_q] < STACK_FULL_CNT)),
    "dispatch moved a job from an empty queue or into a full stack")
  `RRQ_ASSERT(a_result_from_done,
    $rose(out_valid_q) |-> $past(state_q == ST_DONE),
    "result appeared without a finished request")
  `RRQ_ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |=> (!out_valid_o && (state_q == ST_IDLE)),
    "block not idle after reset")

endmodule
